@@ sv/ptnp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptnp_pkg: shared constants for the prime test and next prime unit
// Operand width and the widths derived from it for the candidate, the
// trial divisor, its square and the divider.
// ----------------------------------------------------------------------------
package ptnp_pkg;

    // Width of the signed operand taken from the input value.
    localparam int VALUE_BITS = 32;

    // Candidate width. The next prime may pass the largest operand value
    // at narrow widths but always stays below twice that value.
    localparam int CAND_W = VALUE_BITS;

    // Trial divisors stay a few steps above the square root of the candidate.
    localparam int DIV_W = (CAND_W + 1) / 2 + 2;

    // Width of the squared divisor.
    localparam int SQ_W = 2 * DIV_W;

    // Bit counter of the one-bit-per-cycle divider.
    localparam int BIT_W = $clog2(CAND_W);

    // Width of the next prime result field.
    localparam int NEXT_W = 31;

    // Smallest prime, and the first odd trial divisor.
    localparam int MIN_PRIME     = 2;
    localparam int FIRST_DIVISOR = 3;

    // Divisor increments of the 6k-1 / 6k+1 walk.
    localparam int STEP_SHORT = 2;
    localparam int STEP_LONG  = 4;

endpackage

@@ sv/prime_test_and_next_prime_unit.sv @@
`timescale 1ns / 1ps
// Values of 2 or less go from idle straight to the done state, skipping the search.
// Otherwise each candidate n passes through the even test and, for each of its
// trial divisors (about sqrt(n) / 3 of them for a prime), the square, the compare,
// the single shared restoring divider that retires one quotient bit a cycle, and the check.
// Items: one at a time; o_ready is high only between items.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_valid.
// ----------------------------------------------------------------------------
// prime_test_and_next_prime_unit: trial-division prime test and next prime
// Tests the signed input for primality and searches upward from it for the
// smallest prime greater than or equal to it, using one iterative divider.
// ----------------------------------------------------------------------------
module prime_test_and_next_prime_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel.
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [31:0]                    i_value,
    // Output channel.
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_is_prime,
    output logic [ptnp_pkg::NEXT_W-1:0]    o_next_prime
);

    // The sequencer walks through the candidates. For each candidate it first
    // rejects even numbers, then tries the divisors 3, 5, 7, 11, 13, 17, ...
    // For every divisor the square is registered in ST_SQ and compared with
    // the candidate in ST_CMP; when the square passes the candidate, the
    // candidate is prime. Otherwise the shared divider produces the remainder,
    // and a zero remainder marks the candidate composite, which moves the
    // search on to the next candidate. The very first candidate is the input
    // value itself, so its outcome is also the primality result.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SQ,
        ST_CMP,
        ST_DIV,
        ST_CHK,
        ST_DONE
    } t_state;

    t_state                            r_state, n_state;
    logic [ptnp_pkg::CAND_W-1:0]       r_cand, n_cand;
    logic [ptnp_pkg::DIV_W-1:0]        r_div, n_div;
    logic                              r_step4, n_step4;
    logic [ptnp_pkg::SQ_W-1:0]         r_sq, n_sq;
    logic [ptnp_pkg::DIV_W-1:0]        r_rem, n_rem;
    logic [ptnp_pkg::BIT_W-1:0]        r_bit, n_bit;
    logic                              r_first, n_first;
    logic                              r_is_prime, n_is_prime;
    logic                              r_out_valid, n_out_valid;
    logic                              r_out_prime, n_out_prime;
    logic [ptnp_pkg::NEXT_W-1:0]       r_out_next, n_out_next;

    // Operand view of the input: low VALUE_BITS bits, two's complement.
    logic [ptnp_pkg::VALUE_BITS-1:0]   w_value;
    logic                              w_small;
    // Shared arithmetic.
    logic [ptnp_pkg::SQ_W-1:0]         w_sq;
    logic [ptnp_pkg::SQ_W-1:0]         w_cand_wide;
    logic [ptnp_pkg::DIV_W:0]          w_trial;
    logic [ptnp_pkg::DIV_W:0]          w_div_wide;
    logic [ptnp_pkg::DIV_W:0]          w_diff;
    logic [ptnp_pkg::DIV_W-1:0]        w_div_next;

    assign w_value = i_value[ptnp_pkg::VALUE_BITS-1:0];
    // Negative values and values up to 2 all map to the next prime 2.
    assign w_small = w_value[ptnp_pkg::VALUE_BITS-1]
                   || (w_value[ptnp_pkg::VALUE_BITS-2:0]
                       <= (ptnp_pkg::VALUE_BITS-1)'(ptnp_pkg::MIN_PRIME));

    assign w_sq        = {{ptnp_pkg::DIV_W{1'b0}}, r_div} * {{ptnp_pkg::DIV_W{1'b0}}, r_div};
    assign w_cand_wide = {{(ptnp_pkg::SQ_W - ptnp_pkg::CAND_W){1'b0}}, r_cand};

    // One restoring division step: bring down the next candidate bit.
    assign w_trial    = {r_rem, r_cand[r_bit]};
    assign w_div_wide = {1'b0, r_div};
    assign w_diff     = w_trial - w_div_wide;

    // 3 -> 5 -> 7 -> 11 -> 13 -> 17 -> ...
    always_comb begin
        if (r_div == ptnp_pkg::DIV_W'(ptnp_pkg::FIRST_DIVISOR)) begin
            w_div_next = r_div + ptnp_pkg::DIV_W'(ptnp_pkg::STEP_SHORT);
        end else if (r_step4) begin
            w_div_next = r_div + ptnp_pkg::DIV_W'(ptnp_pkg::STEP_LONG);
        end else begin
            w_div_next = r_div + ptnp_pkg::DIV_W'(ptnp_pkg::STEP_SHORT);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cand      = r_cand;
        n_div       = r_div;
        n_step4     = r_step4;
        n_sq        = r_sq;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_first     = r_first;
        n_is_prime  = r_is_prime;
        n_out_valid = r_out_valid;
        n_out_prime = r_out_prime;
        n_out_next  = r_out_next;

        // The waiting result leaves on its transfer.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (w_small) begin
                        n_is_prime = (w_value == ptnp_pkg::VALUE_BITS'(ptnp_pkg::MIN_PRIME));
                        n_cand     = ptnp_pkg::CAND_W'(ptnp_pkg::MIN_PRIME);
                        n_state    = ST_DONE;
                    end else begin
                        n_cand  = ptnp_pkg::CAND_W'(w_value);
                        n_first = 1'b1;
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                n_div   = ptnp_pkg::DIV_W'(ptnp_pkg::FIRST_DIVISOR);
                n_step4 = 1'b0;
                if (!r_cand[0]) begin
                    // Even and at least 4: composite.
                    if (r_first) begin
                        n_is_prime = 1'b0;
                    end
                    n_first = 1'b0;
                    n_cand  = r_cand + 1'b1;
                end else begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                n_sq    = w_sq;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_sq > w_cand_wide) begin
                    // No divisor up to the square root: prime.
                    if (r_first) begin
                        n_is_prime = 1'b1;
                    end
                    n_first = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    n_rem   = '0;
                    n_bit   = ptnp_pkg::BIT_W'(ptnp_pkg::CAND_W - 1);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_trial >= w_div_wide) begin
                    n_rem = w_diff[ptnp_pkg::DIV_W-1:0];
                end else begin
                    n_rem = w_trial[ptnp_pkg::DIV_W-1:0];
                end
                if (r_bit == '0) begin
                    n_state = ST_CHK;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            ST_CHK: begin
                if (r_rem == '0) begin
                    if (r_first) begin
                        n_is_prime = 1'b0;
                    end
                    n_first = 1'b0;
                    n_cand  = r_cand + 1'b1;
                    n_state = ST_START;
                end else begin
                    if (r_div != ptnp_pkg::DIV_W'(ptnp_pkg::FIRST_DIVISOR)) begin
                        n_step4 = !r_step4;
                    end
                    n_div   = w_div_next;
                    n_state = ST_SQ;
                end
            end
            ST_DONE: begin
                // Load the output register once it is free or being emptied.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_is_prime;
                    n_out_next  = ptnp_pkg::NEXT_W'(r_cand);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cand      <= n_cand;
        r_div       <= n_div;
        r_step4     <= n_step4;
        r_sq        <= n_sq;
        r_rem       <= n_rem;
        r_bit       <= n_bit;
        r_first     <= n_first;
        r_is_prime  <= n_is_prime;
        r_out_prime <= n_out_prime;
        r_out_next  <= n_out_next;
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_is_prime   = r_out_prime;
    assign o_next_prime = r_out_next;

endmodule

@@ sv/ptnp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptnp_checker: port-level checks for the prime test and next prime unit
// Watches the handshakes and the result fields over time.
// ----------------------------------------------------------------------------
module ptnp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic                           o_is_prime,
    input logic [ptnp_pkg::NEXT_W-1:0]    o_next_prime
);

    // A waiting result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_is_prime) && $stable(o_next_prime))
        else $error("result changed before its transfer");

    // The unit is busy after it takes an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while an item is in progress");

    // A reported prime is odd or is 2.
    a_prime_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_prime |-> o_next_prime[0]
            || (o_next_prime == ptnp_pkg::NEXT_W'(ptnp_pkg::MIN_PRIME)))
        else $error("prime result is even and not 2");

    // The next prime is never below the smallest prime.
    a_next_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_next_prime >= ptnp_pkg::NEXT_W'(ptnp_pkg::MIN_PRIME))
        else $error("next prime below 2");

    // Leaving reset, the unit is idle with no result.
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_ready && !o_valid)
        else $error("unit not idle after reset");

endmodule

bind prime_test_and_next_prime_unit ptnp_checker u_ptnp_checker (.*);
